FILE: design/cau_pkg.sv
package cau_pkg;

  // Operation codes carried in the mode field of an input beat.
  localparam int MODE_W = 3;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_ADD      = 3'd0;
  localparam mode_t MODE_SUB      = 3'd1;
  localparam mode_t MODE_SCALE_RE = 3'd2;
  localparam mode_t MODE_SCALE_IM = 3'd3;
  localparam mode_t MODE_MUL      = 3'd4;
  localparam mode_t MODE_MAG      = 3'd5;

endpackage

FILE: design/cau_in_if.sv
interface cau_in_if #(
  parameter int DATA_WIDTH = 16
);

  logic                         valid;
  logic                         ready;
  cau_pkg::mode_t               mode;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);

endinterface

FILE: design/cau_out_if.sv
interface cau_out_if #(
  parameter int DATA_WIDTH = 16
);

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         overflow;

  modport source (output valid, res_re, res_im, overflow, input ready);
  modport sink   (input valid, res_re, res_im, overflow, output ready);

endinterface

FILE: design/cau_isqrt.sv
module cau_isqrt #(
  parameter int DATA_WIDTH = 16,
  parameter int SIDE_W     = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [2*DATA_WIDTH-1:0]   radicand,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [DATA_WIDTH-1:0]     root,
  output logic [SIDE_W-1:0]         side_out
);

  localparam int NST = DATA_WIDTH;
  localparam int RW  = DATA_WIDTH + 2;
  localparam int PW  = 2 * DATA_WIDTH;

  // One root bit per stage; each stage pulls two radicand bits into the remainder.
  logic [NST-1:0]        v_r;
  logic [NST-1:0]        adv;
  logic [RW-1:0]         rem_r  [NST];
  logic [DATA_WIDTH-1:0] root_r [NST];
  logic [PW-1:0]         rad_r  [NST];
  logic [SIDE_W-1:0]     side_r [NST];

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic                  p_valid;
    logic [RW-1:0]         p_rem;
    logic [DATA_WIDTH-1:0] p_root;
    logic [PW-1:0]         p_rad;
    logic [SIDE_W-1:0]     p_side;
    logic                  dn_adv;
    logic [RW-1:0]         rem_sh;
    logic [RW-1:0]         trial;
    logic                  take;
    logic [RW-1:0]         rem_nxt;
    logic [DATA_WIDTH-1:0] root_nxt;
    logic [PW-1:0]         rad_nxt;

    if (j == 0) begin : g_first
      assign p_valid = up_valid;
      assign p_rem   = '0;
      assign p_root  = '0;
      assign p_rad   = radicand;
      assign p_side  = side_in;
    end else begin : g_next
      assign p_valid = v_r[j-1];
      assign p_rem   = rem_r[j-1];
      assign p_root  = root_r[j-1];
      assign p_rad   = rad_r[j-1];
      assign p_side  = side_r[j-1];
    end

    if (j == NST - 1) begin : g_last_adv
      assign dn_adv = dn_ready;
    end else begin : g_mid_adv
      assign dn_adv = adv[j+1];
    end

    assign adv[j] = !v_r[j] || dn_adv;

    always_comb begin
      rem_sh   = {p_rem[DATA_WIDTH-1:0], p_rad[PW-1 -: 2]};
      trial    = {p_root, 2'b01};
      take     = (rem_sh >= trial);
      rem_nxt  = take ? (rem_sh - trial) : rem_sh;
      root_nxt = {p_root[DATA_WIDTH-2:0], take};
      rad_nxt  = {p_rad[PW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv[j]) begin
        v_r[j] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        rad_r[j]  <= rad_nxt;
        side_r[j] <= p_side;
      end
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[NST-1];
  assign root     = root_r[NST-1];
  assign side_out = side_r[NST-1];

endmodule

FILE: design/complex_arith_unit.sv
// Complex-number ALU on signed fixed-point words (DATA_WIDTH bits, FRAC_BITS of
// them fraction; Q8.8 by default). Each input beat on in_ch carries a mode and
// two operands A and B; each accepted beat yields exactly one result beat on
// out_ch, in order. Modes are add, subtract, scale by the real scalar b_re,
// scale by the imaginary scalar j*b_re, full complex multiply and magnitude of A.
// Products keep full precision and are shifted right arithmetically by
// FRAC_BITS (rounding toward minus infinity). Each result part saturates to the
// word range and overflow flags any saturation. Unused modes return all zeros.
// A beat passes through stages A, B and C, the square-root pipeline, which
// retires one root bit per stage, and the output register; every mode goes
// through the same stages so results leave in order. Throughput is one beat
// per cycle while out_ch takes results. Each stage keeps its own valid bit and
// advances when it is empty or its successor advances, so bubbles fill and,
// while out_ch is stalled, new beats are still taken until all DATA_WIDTH + 4
// stages hold work; nothing is dropped or repeated. A synchronous active-low
// reset empties the pipeline; no result beat is shown until new work arrives.
module complex_arith_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input logic       clk,
  input logic       rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;      // full product width
  localparam int WW = 2 * DATA_WIDTH + 1;  // sum of two products
  localparam int SW = DATA_WIDTH + 1;      // sum of two words
  localparam int SIDE_W = 2 * DATA_WIDTH + 2;

  localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [WW-1:0] W_MAX = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WW-1:0] W_MIN = ~W_MAX;

  // Clamp a wide signed value to the word range and report whether it clipped.
  function automatic logic [DW:0] sat_word(input logic signed [WW-1:0] v);
    logic [DW:0] r;
    if (v > W_MAX) begin
      r = {1'b1, D_MAX};
    end else if (v < W_MIN) begin
      r = {1'b1, D_MIN};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  // Handshake chain: a stage may load when it is empty or its successor moves on.
  logic a_adv, b_adv, c_adv, o_adv;
  logic sq_up_ready, sq_dn_valid;

  // Stage A: the four products (operands squared for magnitude) and add/subtract.
  logic                 a_v_r;
  cau_pkg::mode_t       a_mode_r;
  logic signed [PW-1:0] a_prr_r, a_pii_r, a_pri_r, a_pir_r;
  logic signed [SW-1:0] a_sre_r, a_sim_r;

  logic                 in_mag;
  logic signed [DW-1:0] mul_rr_b, mul_ii_b;
  logic signed [PW-1:0] prr_nxt, pii_nxt, pri_nxt, pir_nxt;
  logic signed [SW-1:0] sre_nxt, sim_nxt;

  always_comb begin
    in_mag   = (in_ch.mode == cau_pkg::MODE_MAG);
    mul_rr_b = in_mag ? in_ch.a_re : in_ch.b_re;
    mul_ii_b = in_mag ? in_ch.a_im : in_ch.b_im;
    prr_nxt  = PW'(in_ch.a_re) * PW'(mul_rr_b);
    pii_nxt  = PW'(in_ch.a_im) * PW'(mul_ii_b);
    pri_nxt  = PW'(in_ch.a_re) * PW'(in_ch.b_im);
    pir_nxt  = PW'(in_ch.a_im) * PW'(in_ch.b_re);
    if (in_ch.mode == cau_pkg::MODE_SUB) begin
      sre_nxt = SW'(in_ch.a_re) - SW'(in_ch.b_re);
      sim_nxt = SW'(in_ch.a_im) - SW'(in_ch.b_im);
    end else begin
      sre_nxt = SW'(in_ch.a_re) + SW'(in_ch.b_re);
      sim_nxt = SW'(in_ch.a_im) + SW'(in_ch.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_adv) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_mode_r <= in_ch.mode;
      a_prr_r  <= prr_nxt;
      a_pii_r  <= pii_nxt;
      a_pri_r  <= pri_nxt;
      a_pir_r  <= pir_nxt;
      a_sre_r  <= sre_nxt;
      a_sim_r  <= sim_nxt;
    end
  end

  // Stage B: combine products per mode and drop the fraction bits. The wide
  // sum cannot wrap, so the 64-bit clamp of the arithmetic collapses into the
  // later saturation.
  logic                 b_v_r;
  logic signed [WW-1:0] b_re_r, b_im_r;
  logic [PW-1:0]        b_sq_r;
  logic                 b_mag_r;

  logic signed [WW-1:0] re_nxt, im_nxt, sum_re, sum_im;
  logic [PW-1:0]        sq_nxt;

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    re_nxt = '0;
    im_nxt = '0;
    sq_nxt = $unsigned(a_prr_r) + $unsigned(a_pii_r);
    unique case (a_mode_r)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        re_nxt = WW'(a_sre_r);
        im_nxt = WW'(a_sim_r);
      end
      cau_pkg::MODE_SCALE_RE: begin
        sum_re = WW'(a_prr_r);
        sum_im = WW'(a_pir_r);
        re_nxt = sum_re >>> FRAC_BITS;
        im_nxt = sum_im >>> FRAC_BITS;
      end
      cau_pkg::MODE_SCALE_IM: begin
        sum_re = -WW'(a_pir_r);
        sum_im = WW'(a_prr_r);
        re_nxt = sum_re >>> FRAC_BITS;
        im_nxt = sum_im >>> FRAC_BITS;
      end
      cau_pkg::MODE_MUL: begin
        sum_re = WW'(a_prr_r) - WW'(a_pii_r);
        sum_im = WW'(a_pri_r) + WW'(a_pir_r);
        re_nxt = sum_re >>> FRAC_BITS;
        im_nxt = sum_im >>> FRAC_BITS;
      end
      default: begin
        // Magnitude is finished after the root; unused modes stay zero.
        re_nxt = '0;
        im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      b_re_r  <= re_nxt;
      b_im_r  <= im_nxt;
      b_sq_r  <= sq_nxt;
      b_mag_r <= (a_mode_r == cau_pkg::MODE_MAG);
    end
  end

  // Stage C: saturate both parts; the result then rides the root pipeline.
  logic          c_v_r;
  logic [PW-1:0] c_sq_r;
  logic [SIDE_W-1:0] c_side_r;

  logic [DW:0] sat_re, sat_im;

  always_comb begin
    sat_re = sat_word(b_re_r);
    sat_im = sat_word(b_im_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      c_sq_r   <= b_sq_r;
      c_side_r <= {b_mag_r, sat_re[DW] | sat_im[DW], sat_re[DW-1:0], sat_im[DW-1:0]};
    end
  end

  // Root pipeline: DATA_WIDTH stages, one root bit each.
  logic [DW-1:0]     sq_root;
  logic [SIDE_W-1:0] sq_side;

  cau_isqrt #(
    .DATA_WIDTH (DATA_WIDTH),
    .SIDE_W     (SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_v_r),
    .up_ready (sq_up_ready),
    .radicand (c_sq_r),
    .side_in  (c_side_r),
    .dn_valid (sq_dn_valid),
    .dn_ready (o_adv),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // Output register: a magnitude above the positive maximum saturates.
  logic                 o_v_r;
  logic signed [DW-1:0] o_re_r, o_im_r;
  logic                 o_ovf_r;

  logic                 fin_mag;
  logic signed [DW-1:0] fin_re, fin_im;
  logic                 fin_ovf;

  always_comb begin
    fin_mag = sq_side[SIDE_W-1];
    if (fin_mag) begin
      fin_ovf = sq_root[DW-1];
      fin_re  = sq_root[DW-1] ? D_MAX : $signed(sq_root);
      fin_im  = '0;
    end else begin
      fin_ovf = sq_side[SIDE_W-2];
      fin_re  = $signed(sq_side[2*DW-1:DW]);
      fin_im  = $signed(sq_side[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_adv) begin
      o_v_r <= sq_dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      o_re_r  <= fin_re;
      o_im_r  <= fin_im;
      o_ovf_r <= fin_ovf;
    end
  end

  assign o_adv = !o_v_r || out_ch.ready;
  assign c_adv = !c_v_r || sq_up_ready;
  assign b_adv = !b_v_r || c_adv;
  assign a_adv = !a_v_r || b_adv;

  assign in_ch.ready     = a_adv;
  assign out_ch.valid    = o_v_r;
  assign out_ch.res_re   = o_re_r;
  assign out_ch.res_im   = o_im_r;
  assign out_ch.overflow = o_ovf_r;

endmodule

FILE: design/cau_checker.sv
module cau_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] res_re,
  input logic [DATA_WIDTH-1:0] res_im,
  input logic                  overflow
);

  localparam int DEPTH = DATA_WIDTH + 4;
  localparam int CW    = $clog2(DEPTH + 2);

  localparam logic [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Beats accepted but not yet delivered.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          in_beat, out_beat;

  always_comb begin
    in_beat  = in_valid && in_ready;
    out_beat = out_valid && out_ready;
    cnt_nxt  = cnt_r + CW'(in_beat) - CW'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
      && $stable(overflow))
    else $error("result beat changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result beat without a pending input beat");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> (res_re == D_MAX || res_re == D_MIN
      || res_im == D_MAX || res_im == D_MIN))
    else $error("overflow set on an unsaturated result");

endmodule

bind complex_arith_unit cau_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res_re    (out_ch.res_re),
  .res_im    (out_ch.res_im),
  .overflow  (out_ch.overflow)
);

FILE: verif/tb_complex_arith_unit.sv
module tb_complex_arith_unit;

  localparam int DW = 16;
  localparam int FB = 8;

  // Word extremes and a few handy Q8.8 values.
  localparam logic signed [DW-1:0] W_MAX = 16'sh7FFF;
  localparam logic signed [DW-1:0] W_MIN = 16'sh8000;
  localparam logic signed [DW-1:0] ONE   = 16'sh0100;

  // Codes that the package leaves unnamed; the block must answer them with zeros.
  localparam cau_pkg::mode_t MODE_SPARE_6 = 3'd6;
  localparam cau_pkg::mode_t MODE_SPARE_7 = 3'd7;

  // Stimulus shape. The counts refer to beats accepted on the input side and
  // beats taken on the result side respectively.
  localparam int RANDOM_OPS    = 1850;
  localparam int DRAIN_AT      = 700;   // sender pauses here until all results are back
  localparam int RX_HOLD_AT    = 300;   // receiver starts its long hold-off here
  localparam int RX_HOLD_LEN   = 80;    // longer than the pipeline depth of 20 stages
  localparam int STEADY_LO     = 1100;  // window with no idling on either side
  localparam int STEADY_HI     = 1400;
  localparam int IDLE_PCT      = 11;
  localparam int TAIL_CYCLES   = 40;    // longer than the pipeline latency
  localparam int MAX_REPORTS   = 60;

  typedef struct packed {
    cau_pkg::mode_t          mode;
    logic signed [DW-1:0]    a_re;
    logic signed [DW-1:0]    a_im;
    logic signed [DW-1:0]    b_re;
    logic signed [DW-1:0]    b_im;
  } cplx_op_t;

  typedef struct packed {
    logic signed [DW-1:0]    re;
    logic signed [DW-1:0]    im;
    logic                    ovf;
  } cplx_res_t;

  logic clk;
  logic rst_n;

  cau_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  cau_out_if #(.DATA_WIDTH(DW)) out_ch ();

  complex_arith_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Operations waiting to be offered, and the results owed by the block for
  // operations it has already accepted, oldest first.
  cplx_op_t  pending_ops[$];
  cplx_res_t owed_results[$];

  cplx_op_t  offered;
  cplx_res_t want;
  int        n_accepted;
  int        n_results;
  int        mismatches;
  int        rx_hold_left;
  logic      draining;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is done in 64-bit signed integers, which hold
  // every product and every sum of two products of 16-bit words exactly, so no
  // intermediate clamp is ever needed at this width.
  // ---------------------------------------------------------------------------

  function automatic logic word_fits(longint v);
    return (v <= longint'(W_MAX)) && (v >= longint'(W_MIN));
  endfunction

  function automatic logic signed [DW-1:0] clip_word(longint v);
    if (v > longint'(W_MAX)) begin
      return W_MAX;
    end
    if (v < longint'(W_MIN)) begin
      return W_MIN;
    end
    return v[DW-1:0];
  endfunction

  // Largest r with r*r <= n, built one bit at a time from the top.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= n) begin
        r = trial;
      end
    end
    return r;
  endfunction

  function automatic cplx_res_t compute_result(cplx_op_t op);
    longint    ar;
    longint    ai;
    longint    br;
    longint    bi;
    longint    re;
    longint    im;
    cplx_res_t r;
    ar = longint'(op.a_re);
    ai = longint'(op.a_im);
    br = longint'(op.b_re);
    bi = longint'(op.b_im);
    re = 0;
    im = 0;
    // An arithmetic right shift of a signed product is a floor division by
    // 2^FB, which is exactly the rounding toward minus infinity we need.
    case (op.mode)
      cau_pkg::MODE_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::MODE_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::MODE_SCALE_RE: begin
        re = (ar * br) >>> FB;
        im = (ai * br) >>> FB;
      end
      cau_pkg::MODE_SCALE_IM: begin
        // j*s*(a_re + j a_im) = -s*a_im + j s*a_re
        re = (-(ai * br)) >>> FB;
        im = (ar * br) >>> FB;
      end
      cau_pkg::MODE_MUL: begin
        re = (ar * br - ai * bi) >>> FB;
        im = (ar * bi + ai * br) >>> FB;
      end
      cau_pkg::MODE_MAG: begin
        // The sum of squares carries 2*FB fraction bits, so its root has FB.
        re = longint'(root_floor(longint'(ar * ar + ai * ai)));
        im = 0;
      end
      default: begin
        return '0;
      end
    endcase
    r.re  = clip_word(re);
    r.im  = clip_word(im);
    r.ovf = !word_fits(re) || !word_fits(im);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  task automatic queue_op(input cau_pkg::mode_t m, input logic signed [DW-1:0] ar,
                          input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                          input logic signed [DW-1:0] bi);
    cplx_op_t op;
    op.mode = m;
    op.a_re = ar;
    op.a_im = ai;
    op.b_re = br;
    op.b_im = bi;
    pending_ops.push_back(op);
  endtask

  // Operand values: a quarter full-range words, half small values (within
  // +/-8.0, so products and magnitudes mostly stay in range and the rounding
  // is exercised), and a quarter picked from the corners of the range.
  function automatic logic signed [DW-1:0] pick_word();
    logic [DW-1:0] w;
    case ($urandom_range(3))
      0: w = DW'($urandom);
      1, 2: w = DW'($urandom_range(4095) - 2048);
      default: begin
        case ($urandom_range(6))
          0: w = W_MAX;
          1: w = W_MIN;
          2: w = '0;
          3: w = '1;
          4: w = DW'(1);
          5: w = ONE;
          default: w = -ONE;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic cau_pkg::mode_t pick_mode();
    if ($urandom_range(99) < 6) begin
      return $urandom_range(1) ? MODE_SPARE_7 : MODE_SPARE_6;
    end
    return cau_pkg::mode_t'($urandom_range(5));
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. An accepted beat is predicted on the edge that accepts it.
  // A beat that is offered but not yet taken is held unchanged. Once the
  // accepted count reaches DRAIN_AT the sender stops offering until the block
  // has returned every owed result.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        owed_results.push_back(compute_result(offered));
        n_accepted++;
        if (n_accepted == DRAIN_AT) begin
          draining = 1'b1;
        end
      end
      if (draining && owed_results.size() == 0) begin
        draining = 1'b0;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (draining || pending_ops.size() == 0 ||
            (!(n_accepted >= STEADY_LO && n_accepted < STEADY_HI) &&
             $urandom_range(99) < IDLE_PCT)) begin
          in_ch.valid <= 1'b0;
        end else begin
          offered = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode  <= offered.mode;
          in_ch.a_re  <= offered.a_re;
          in_ch.a_im  <= offered.a_im;
          in_ch.b_re  <= offered.b_re;
          in_ch.b_im  <= offered.b_im;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Each taken beat is checked field by field against the
  // oldest owed result. After RX_HOLD_AT results the receiver drops ready for
  // a long stretch so that the pipeline fills and must stall its input.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: unexpected result beat re=%0d im=%0d overflow=%0b",
                     $time, out_ch.res_re, out_ch.res_im, out_ch.overflow);
          end
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_ch.res_re !== want.re) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: res_re mismatch, expected %0d actual %0d",
                       $time, want.re, out_ch.res_re);
            end
            mismatches++;
          end
          if (out_ch.res_im !== want.im) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: res_im mismatch, expected %0d actual %0d",
                       $time, want.im, out_ch.res_im);
            end
            mismatches++;
          end
          if (out_ch.overflow !== want.ovf) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: overflow mismatch, expected %0b actual %0b",
                       $time, want.ovf, out_ch.overflow);
            end
            mismatches++;
          end
        end
        n_results++;
        if (n_results == RX_HOLD_AT) begin
          rx_hold_left = RX_HOLD_LEN;
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (n_results >= STEADY_LO && n_results < STEADY_HI) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: directed corners first, then random operations, then wait
  // for the block to return everything it owes.
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = cau_pkg::MODE_ADD;
    in_ch.a_re   = '0;
    in_ch.a_im   = '0;
    in_ch.b_re   = '0;
    in_ch.b_im   = '0;
    out_ch.ready = 1'b0;
    n_accepted   = 0;
    n_results    = 0;
    mismatches   = 0;
    rx_hold_left = 0;
    draining     = 1'b0;

    // Add and subtract: saturation at both ends, then an ordinary case.
    queue_op(cau_pkg::MODE_ADD, W_MAX, W_MAX, W_MAX, W_MAX);
    queue_op(cau_pkg::MODE_ADD, W_MIN, W_MIN, W_MIN, W_MIN);
    queue_op(cau_pkg::MODE_ADD, 16'sh0180, -16'sh0240, 16'sh0040, ONE);
    queue_op(cau_pkg::MODE_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
    queue_op(cau_pkg::MODE_SUB, 16'sh0000, 16'sh0000, W_MIN, W_MIN);
    queue_op(cau_pkg::MODE_SUB, 16'sh0300, -16'sh0100, 16'sh0080, 16'sh0200);
    // Real scaling: the largest product, rounding of a tiny negative product
    // toward minus infinity, and an ordinary case with b_im as noise.
    queue_op(cau_pkg::MODE_SCALE_RE, W_MIN, W_MIN, W_MIN, W_MAX);
    queue_op(cau_pkg::MODE_SCALE_RE, -16'sh0001, 16'sh0001, 16'sh0001, W_MIN);
    queue_op(cau_pkg::MODE_SCALE_RE, 16'sh0200, -16'sh0300, 16'sh0080, 16'sh1234);
    // Imaginary scaling: sign flip of the largest product, small rounding.
    queue_op(cau_pkg::MODE_SCALE_IM, W_MIN, W_MIN, W_MIN, 16'sh0000);
    queue_op(cau_pkg::MODE_SCALE_IM, 16'sh0001, 16'sh0001, 16'sh0001, W_MAX);
    queue_op(cau_pkg::MODE_SCALE_IM, 16'sh0100, 16'sh0200, -16'sh0180, 16'sh0000);
    // Complex multiply: cancelling real part with saturated imaginary part,
    // a real part past the range, and (1+2j)(3+4j).
    queue_op(cau_pkg::MODE_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
    queue_op(cau_pkg::MODE_MUL, W_MAX, W_MIN, W_MAX, W_MAX);
    queue_op(cau_pkg::MODE_MUL, ONE, 16'sh0200, 16'sh0300, 16'sh0400);
    queue_op(cau_pkg::MODE_MUL, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
    // Magnitude: beyond the positive maximum, zero, 3-4-5, the axis extremes,
    // and the smallest nonzero input. Operand B is noise here.
    queue_op(cau_pkg::MODE_MAG, W_MIN, W_MIN, W_MAX, W_MIN);
    queue_op(cau_pkg::MODE_MAG, 16'sh0000, 16'sh0000, 16'sh7777, -16'sh0001);
    queue_op(cau_pkg::MODE_MAG, 16'sh0300, -16'sh0400, 16'sh0000, 16'sh0000);
    queue_op(cau_pkg::MODE_MAG, W_MAX, 16'sh0000, W_MIN, W_MAX);
    queue_op(cau_pkg::MODE_MAG, W_MIN, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_op(cau_pkg::MODE_MAG, -16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    // The two spare codes must return zeros and no overflow.
    queue_op(MODE_SPARE_6, W_MAX, W_MAX, W_MAX, W_MAX);
    queue_op(MODE_SPARE_7, W_MIN, W_MIN, W_MIN, W_MIN);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      queue_op(pick_mode(), pick_word(), pick_word(), pick_word(), pick_word());
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every operation offered and taken, then every result back, then a
    // quiet tail in which any extra result beat would be flagged.
    while (pending_ops.size() != 0 || in_ch.valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("complex_arith_unit regression: pass");
    end else begin
      $display("complex_arith_unit regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("complex_arith_unit regression: fail");
    $finish;
  end

endmodule
